FILE: rtl/lslc_pkg.sv
// ----------------------------------------------------------------------------
// lslc_pkg
// Shared types, constants and the arctangent table for the scan clustering
// block.
// ----------------------------------------------------------------------------
`default_nettype none
package lslc_pkg;

  localparam int MAX_BEAMS   = 4096;
  localparam int IDX_W       = 13;
  localparam int CORDIC_N    = 18;
  localparam int DIV_N       = 32;
  localparam int ITER_W      = 5;
  localparam int XY_W        = 36;
  localparam int Z_W         = 26;
  localparam int PT_W        = 18;
  localparam int SUM_W       = 31;
  localparam int SQ_W        = 38;
  localparam int RT_W        = 37;
  localparam int OUT_DATA_W  = 88;
  localparam logic [15:0] INV_GAIN = 16'd39797;

  // configuration register indexes
  localparam logic [2:0] REG_RANGE_MIN = 3'd0;
  localparam logic [2:0] REG_RANGE_MAX = 3'd1;
  localparam logic [2:0] REG_ANG_START = 3'd2;
  localparam logic [2:0] REG_ANG_STEP  = 3'd3;
  localparam logic [2:0] REG_BEAM_LIM  = 3'd4;
  localparam logic [2:0] REG_OFFSET_X  = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd6;
  localparam logic [2:0] REG_GAP       = 3'd7;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DX,
    MUL_DY,
    MUL_GAP,
    MUL_CX,
    MUL_CY
  } mul_sel_t;

  typedef struct packed {
    logic              accept;
    logic              rot_init;
    logic              step;
    logic              vec;
    logic              vinit;
    logic              pt;
    mul_sel_t          mul;
    logic              cmp;
    logic              grow;
    logic              start;
    logic              clear;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic              last;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic keep;
    logic eos;
    logic open;
    logic near;
    logic out_free;
  } status_t;

  function automatic logic [21:0] atan_f(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lslc_ctrl.sv
// ----------------------------------------------------------------------------
// lslc_ctrl
// Sequencer: walks each beam through point conversion, neighbour test and
// cluster update, and runs the centroid, range and bearing steps on emit.
// ----------------------------------------------------------------------------
`default_nettype none
module lslc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire lslc_pkg::status_t sts,
  output lslc_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ROT_INIT, S_ROT, S_PT, S_D1, S_D2, S_D3, S_CMP,
    S_DECIDE, S_JOIN, S_START, S_EOS, S_DIV_INIT, S_DIV, S_SQ1, S_SQ2,
    S_VINIT, S_VEC, S_OUT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lslc_pkg::ITER_W-1:0]   cnt_r, cnt_nxt;
  logic                          last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.mul   = lslc_pkg::MUL_NONE;
    cmd.iter  = cnt_r;
    cmd.last  = last_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK:    state_nxt = sts.keep ? S_ROT_INIT : S_EOS;
      S_ROT_INIT: begin
        cmd.rot_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_ROT;
      end
      S_ROT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == lslc_pkg::ITER_W'(lslc_pkg::CORDIC_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        cmd.pt    = 1'b1;
        state_nxt = sts.open ? S_D1 : S_START;
      end
      S_D1: begin
        cmd.mul   = lslc_pkg::MUL_DX;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.mul   = lslc_pkg::MUL_DY;
        state_nxt = S_D3;
      end
      S_D3: begin
        cmd.mul   = lslc_pkg::MUL_GAP;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.near) begin
          state_nxt = S_JOIN;
        end else begin
          last_nxt  = 1'b0;
          state_nxt = S_DIV_INIT;
        end
      end
      S_JOIN: begin
        cmd.grow  = 1'b1;
        state_nxt = S_EOS;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_EOS;
      end
      S_EOS: begin
        if (sts.eos && sts.open) begin
          last_nxt  = 1'b1;
          state_nxt = S_DIV_INIT;
        end else begin
          cmd.clear = sts.eos;
          state_nxt = S_IDLE;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == lslc_pkg::ITER_W'(lslc_pkg::DIV_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.mul   = lslc_pkg::MUL_CX;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.mul   = lslc_pkg::MUL_CY;
        state_nxt = S_VINIT;
      end
      S_VINIT: begin
        cmd.vinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        cmd.step = 1'b1;
        cmd.vec  = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == lslc_pkg::ITER_W'(lslc_pkg::CORDIC_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (last_r) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lslc_dp.sv
// ----------------------------------------------------------------------------
// lslc_dp
// Datapath: settings, beam counter, shared CORDIC, shared multiplier,
// centroid dividers, square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lslc_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [15:0]                    cfg_data,
  input  wire logic                           in_tvalid,
  input  wire logic [15:0]                    in_tdata,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lslc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  wire lslc_pkg::cmd_t                 cmd,
  output lslc_pkg::status_t                   sts
);

  // settings
  logic [15:0]        rmin_r, rmax_r, ang0_r, gap_r;
  logic [11:0]        astep_r;
  logic [12:0]        blim_r;
  logic signed [15:0] offx_r, offy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmin_r  <= 16'd100;
      rmax_r  <= 16'd30000;
      ang0_r  <= 16'd0;
      astep_r <= 12'd64;
      blim_r  <= 13'd4096;
      offx_r  <= 16'sd0;
      offy_r  <= 16'sd0;
      gap_r   <= 16'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lslc_pkg::REG_RANGE_MIN: rmin_r  <= cfg_data;
        lslc_pkg::REG_RANGE_MAX: rmax_r  <= cfg_data;
        lslc_pkg::REG_ANG_START: ang0_r  <= cfg_data;
        lslc_pkg::REG_ANG_STEP:  astep_r <= cfg_data[11:0];
        lslc_pkg::REG_BEAM_LIM:  blim_r  <= cfg_data[12:0];
        lslc_pkg::REG_OFFSET_X:  offx_r  <= signed'(cfg_data);
        lslc_pkg::REG_OFFSET_Y:  offy_r  <= signed'(cfg_data);
        lslc_pkg::REG_GAP:       gap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // beam intake
  logic [lslc_pkg::IDX_W-1:0] idx_r;
  logic [15:0]                rng_r, ang_r;
  logic                       eos_r, keep_r;
  logic                       take;
  logic [24:0]                ang_prod;
  logic                       idx_ok;

  assign take     = cmd.accept && in_tvalid;
  assign ang_prod = astep_r * idx_r;
  assign idx_ok   = (idx_r < lslc_pkg::IDX_W'(lslc_pkg::MAX_BEAMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      keep_r <= 1'b0;
      eos_r  <= 1'b0;
    end else if (take) begin
      keep_r <= idx_ok && (idx_r < blim_r) && (in_tdata > rmin_r) && (in_tdata < rmax_r);
      eos_r  <= in_tlast;
      if (in_tlast)    idx_r <= '0;
      else if (idx_ok) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rng_r <= in_tdata;
      ang_r <= ang0_r + ang_prod[15:0];
    end
  end

  // shared CORDIC, rotation for the beam point, vectoring for the bearing
  logic signed [lslc_pkg::XY_W-1:0] cx_r, cy_r, xs, ys, x0, vx0, vy0;
  logic signed [lslc_pkg::Z_W-1:0]  cz_r, at;
  logic [31:0]                      rprod;
  logic [15:0]                      afold, aplus;
  logic                             d_neg;
  logic [17:0]                      cen_x, cen_y;

  assign rprod = rng_r * lslc_pkg::INV_GAIN;
  assign x0    = signed'({4'b0, rprod});
  assign aplus = ang_r + 16'd16384;
  assign afold = aplus[15] ? (ang_r + 16'd32768) : ang_r;
  assign xs    = cx_r >>> cmd.iter;
  assign ys    = cy_r >>> cmd.iter;
  assign at    = signed'({4'b0, lslc_pkg::atan_f(cmd.iter)});
  assign d_neg = cmd.vec ? (cy_r > 0) : cz_r[lslc_pkg::Z_W-1];
  assign vx0   = signed'({{6{cen_x[17]}}, cen_x, 12'b0});
  assign vy0   = signed'({{6{cen_y[17]}}, cen_y, 12'b0});

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      cx_r <= aplus[15] ? -x0 : x0;
      cy_r <= '0;
      cz_r <= signed'({{2{afold[15]}}, afold, 8'b0});
    end else if (cmd.vinit) begin
      cx_r <= cen_x[17] ? -vx0 : vx0;
      cy_r <= cen_x[17] ? -vy0 : vy0;
      cz_r <= cen_x[17] ? signed'(lslc_pkg::Z_W'(24'h800000)) : '0;
    end else if (cmd.step) begin
      if (d_neg) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
    end
  end

  // point in robot frame
  logic signed [lslc_pkg::PT_W-1:0] px_r, py_r, prev_x_r, prev_y_r;
  logic signed [lslc_pkg::XY_W-1:0] xr, yr;

  assign xr = (cx_r + lslc_pkg::XY_W'(32768)) >>> 16;
  assign yr = (cy_r + lslc_pkg::XY_W'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.pt) begin
      px_r <= xr[lslc_pkg::PT_W-1:0] + lslc_pkg::PT_W'(offx_r);
      py_r <= yr[lslc_pkg::PT_W-1:0] + lslc_pkg::PT_W'(offy_r);
    end
  end

  // shared multiplier
  logic signed [18:0]                ma;
  logic signed [lslc_pkg::SQ_W-1:0]  prod;
  logic [lslc_pkg::SQ_W-1:0]         sq_a_r, sq_b_r, sq_g_r;
  logic                              near_r;

  always_comb begin
    unique case (cmd.mul)
      lslc_pkg::MUL_DX:  ma = 19'(px_r) - 19'(prev_x_r);
      lslc_pkg::MUL_DY:  ma = 19'(py_r) - 19'(prev_y_r);
      lslc_pkg::MUL_GAP: ma = signed'({3'b0, gap_r});
      lslc_pkg::MUL_CX:  ma = signed'({cen_x[17], cen_x});
      lslc_pkg::MUL_CY:  ma = signed'({cen_y[17], cen_y});
      default:           ma = '0;
    endcase
  end

  assign prod = ma * ma;

  always_ff @(posedge clk) begin
    unique case (cmd.mul)
      lslc_pkg::MUL_DX, lslc_pkg::MUL_CX: sq_a_r <= prod;
      lslc_pkg::MUL_DY, lslc_pkg::MUL_CY: sq_b_r <= prod;
      lslc_pkg::MUL_GAP:                  sq_g_r <= prod;
      default: ;
    endcase
    if (cmd.cmp) near_r <= ({1'b0, sq_a_r} + {1'b0, sq_b_r}) <= {1'b0, sq_g_r};
  end

  // cluster accumulators
  logic signed [lslc_pkg::SUM_W-1:0] sum_x_r, sum_y_r;
  logic [lslc_pkg::IDX_W-1:0]        size_r;
  logic                              open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      size_r <= '0;
    end else if (cmd.start) begin
      open_r <= 1'b1;
      size_r <= lslc_pkg::IDX_W'(1);
    end else if (cmd.grow) begin
      size_r <= size_r + 1'b1;
    end else if (cmd.clear) begin
      open_r <= 1'b0;
      size_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_x_r  <= lslc_pkg::SUM_W'(px_r);
      sum_y_r  <= lslc_pkg::SUM_W'(py_r);
      prev_x_r <= px_r;
      prev_y_r <= py_r;
    end else if (cmd.grow) begin
      sum_x_r  <= sum_x_r + lslc_pkg::SUM_W'(px_r);
      sum_y_r  <= sum_y_r + lslc_pkg::SUM_W'(py_r);
      prev_x_r <= px_r;
      prev_y_r <= py_r;
    end
  end

  // centroid: restoring division of |sum| + size/2 by size, one bit a cycle
  logic [31:0]                nx_r, ny_r;
  logic [lslc_pkg::IDX_W-1:0] rx_r, ry_r;
  logic                       sgx_r, sgy_r;
  logic [31:0]                magx, magy, negx, negy;
  logic [lslc_pkg::IDX_W:0]   remx2, remy2;
  logic                       gex, gey;

  assign magx  = sum_x_r[lslc_pkg::SUM_W-1] ? 32'(-sum_x_r) : 32'(sum_x_r);
  assign magy  = sum_y_r[lslc_pkg::SUM_W-1] ? 32'(-sum_y_r) : 32'(sum_y_r);
  assign remx2 = {rx_r, nx_r[31]};
  assign remy2 = {ry_r, ny_r[31]};
  assign gex   = remx2 >= {1'b0, size_r};
  assign gey   = remy2 >= {1'b0, size_r};
  assign negx  = 32'd0 - nx_r;
  assign negy  = 32'd0 - ny_r;
  assign cen_x = sgx_r ? negx[17:0] : nx_r[17:0];
  assign cen_y = sgy_r ? negy[17:0] : ny_r[17:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      nx_r  <= magx + 32'(size_r >> 1);
      ny_r  <= magy + 32'(size_r >> 1);
      rx_r  <= '0;
      ry_r  <= '0;
      sgx_r <= sum_x_r[lslc_pkg::SUM_W-1];
      sgy_r <= sum_y_r[lslc_pkg::SUM_W-1];
    end else if (cmd.div_step) begin
      rx_r <= gex ? lslc_pkg::IDX_W'(remx2 - {1'b0, size_r}) : remx2[lslc_pkg::IDX_W-1:0];
      ry_r <= gey ? lslc_pkg::IDX_W'(remy2 - {1'b0, size_r}) : remy2[lslc_pkg::IDX_W-1:0];
      nx_r <= {nx_r[30:0], gex};
      ny_r <= {ny_r[30:0], gey};
    end
  end

  // range: digit-by-digit square root, run alongside the vectoring pass
  logic [lslc_pkg::RT_W-1:0] rem_r, q_r, bit_r, trial, q_up;
  logic                      zero_r;

  assign trial = q_r + bit_r;
  assign q_up  = (rem_r > q_r) ? q_r + 1'b1 : q_r;

  always_ff @(posedge clk) begin
    if (cmd.vinit) begin
      rem_r  <= lslc_pkg::RT_W'(sq_a_r) + lslc_pkg::RT_W'(sq_b_r);
      q_r    <= '0;
      bit_r  <= lslc_pkg::RT_W'(1) << 34;
      zero_r <= (cen_x == '0) && (cen_y == '0);
    end else if (cmd.step && cmd.vec) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        q_r   <= (q_r >> 1) + bit_r;
      end else begin
        q_r   <= q_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  logic                              ovalid_r;
  logic [lslc_pkg::OUT_DATA_W-1:0]   odata_r;
  logic                              olast_r;
  logic [16:0]                       range_v;
  logic [lslc_pkg::Z_W-1:0]          zr;
  logic [15:0]                       bear_v;

  assign range_v = (q_up > lslc_pkg::RT_W'(131071)) ? 17'd131071 : q_up[16:0];
  assign zr      = cz_r + lslc_pkg::Z_W'(128);
  assign bear_v  = zero_r ? 16'd0 : zr[23:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {6'b0, size_r, bear_v, range_v, cen_y, cen_x};
      olast_r <= cmd.last;
    end
  end

  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;
  assign out_tlast    = olast_r;

  assign sts.keep     = keep_r;
  assign sts.eos      = eos_r;
  assign sts.open     = open_r;
  assign sts.near     = near_r;
  assign sts.out_free = !ovalid_r;

endmodule
`default_nettype wire

FILE: rtl/laser_scan_landmark_clustering.sv
// ----------------------------------------------------------------------------
// laser_scan_landmark_clustering
// Converts beam ranges to points and groups neighbouring points into
// landmarks, reporting centroid, range, bearing and point count.
// ----------------------------------------------------------------------------
// a discarded beam skips the CORDIC; a kept beam opens a cluster or first
// runs the neighbour test (18 CORDIC steps, one shared multiplier); a landmark
// adds a 32-step centroid division, then 18 vectoring steps with the root,
// and waits for the result word to leave; a break at scan end emits two
// landmarks for the one beam; one beam in flight
// synchronous reset restores the default settings and an empty cluster
`default_nettype none
module laser_scan_landmark_clustering (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] beam_range_mm
  input  wire logic        in_tlast,   // end_of_scan
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [17:0] centroid_x_mm, [35:18] centroid_y_mm, [52:36] landmark_range_mm,
  // [68:53] landmark_bearing, [81:69] point_count, [87:82] zero
  output logic [87:0]      out_tdata,
  output logic             out_tlast   // last_of_scan
);

  lslc_pkg::cmd_t    cmd;
  lslc_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  lslc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lslc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one beam at a time
  a_one_beam: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("beam taken while previous beam still in work");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[81:69] != 13'd0))
    else $error("landmark with no points");

  a_origin_bearing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[17:0] == 18'd0) && (out_tdata[35:18] == 18'd0)
      |-> (out_tdata[68:53] == 16'd0))
    else $error("nonzero bearing for centroid at origin");

endmodule
`default_nettype wire

FILE: tb/sv/laser_scan_landmark_clustering_test.sv
// ----------------------------------------------------------------------------
// laser_scan_landmark_clustering_test
// Self-checking bench: drives beam ranges and register writes, predicts every
// landmark in its own fixed-point model of the clustering and compares each
// result word field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module laser_scan_landmark_clustering_test;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 2000;

  typedef struct {
    logic [17:0] cx;
    logic [17:0] cy;
    logic [16:0] rng;
    logic [15:0] brg;
    logic [12:0] cnt;
    logic        last;
  } landmark_t;

  localparam int ATAN_TAB [18] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
    41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = lslc_pkg::REG_RANGE_MIN;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] beam_range_mm
  logic        in_tlast = 1'b0; // end_of_scan
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [17:0] cx, [35:18] cy, [52:36] range, [68:53] bearing, [81:69] count
  logic [87:0] out_tdata;
  logic        out_tlast;

  // predictor copy of settings and cluster state
  int unsigned rmin, rmax, ang0, astep, blim, gap_mm;
  int          offx, offy;
  int unsigned beam_idx, clu_size;
  bit          clu_open;
  longint      last_px, last_py, acc_x, acc_y;

  landmark_t landmark_q[$];
  int  failures = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;

  laser_scan_landmark_clustering i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic void beam_to_point(int unsigned r, int unsigned ang,
                                        output longint px, output longint py);
    longint x, y, z, xs, ys;
    int unsigned a;
    x = longint'(r) * 39797;
    y = 0;
    a = ang & 16'hFFFF;
    if (((a + 16384) & 16'hFFFF) >= 32768) begin
      x = -x;
      a = (a + 32768) & 16'hFFFF;
    end
    z = longint'($signed(a[15:0])) * 256;
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end
    end
    px = ((x + 32768) >>> 16) + offx;
    py = ((y + 32768) >>> 16) + offy;
  endfunction

  function automatic longint round_div(longint s, int unsigned n);
    longint m, q;
    m = (s < 0) ? -s : s;
    q = (m + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic int unsigned round_sqrt(longint unsigned s);
    longint unsigned q, b, rem;
    q = 0;
    b = 64'd1 << 62;
    rem = s;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= q + b) begin
        rem -= q + b;
        q = (q >> 1) + b;
      end else begin
        q >>= 1;
      end
      b >>= 2;
    end
    if (s - q * q > q) q++;
    return (q > 131071) ? 131071 : int'(q);
  endfunction

  function automatic int unsigned bearing_units(longint cx, longint cy);
    longint x, y, xs, ys;
    int unsigned z;
    if (cx == 0 && cy == 0) return 0;
    x = cx * 4096;
    y = cy * 4096;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 1 << 23;
    end
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return ((z + 128) >> 8) & 16'hFFFF;
  endfunction

  function automatic void push_landmark(bit last);
    landmark_t lm;
    longint cx, cy;
    cx = round_div(acc_x, clu_size);
    cy = round_div(acc_y, clu_size);
    lm.cx   = cx[17:0];
    lm.cy   = cy[17:0];
    lm.rng  = 17'(round_sqrt(longint'(cx * cx + cy * cy)));
    lm.brg  = 16'(bearing_units(cx, cy));
    lm.cnt  = 13'(clu_size);
    lm.last = last;
    landmark_q.insert(landmark_q.size(), lm);
  endfunction

  function automatic void clear_cluster();
    clu_open = 1'b0;
    last_px = 0; last_py = 0;
    acc_x = 0; acc_y = 0;
    clu_size = 0;
  endfunction

  function automatic void begin_cluster(longint px, longint py);
    clu_open = 1'b1;
    acc_x = px; acc_y = py;
    last_px = px; last_py = py;
    clu_size = 1;
  endfunction

  function automatic void predict_beam(int unsigned r, bit eos);
    longint px, py, dx, dy;
    if (beam_idx < lslc_pkg::MAX_BEAMS && beam_idx < blim && r > rmin && r < rmax) begin
      beam_to_point(r, ang0 + astep * beam_idx, px, py);
      if (clu_open) begin
        dx = px - last_px;
        dy = py - last_py;
        if (dx * dx + dy * dy <= longint'(gap_mm) * gap_mm) begin
          acc_x += px; acc_y += py;
          last_px = px; last_py = py;
          clu_size++;
        end else begin
          push_landmark(1'b0);
          begin_cluster(px, py);
        end
      end else begin
        begin_cluster(px, py);
      end
    end
    if (beam_idx < lslc_pkg::MAX_BEAMS) beam_idx++;
    if (eos) begin
      if (clu_open) push_landmark(1'b1);
      clear_cluster();
      beam_idx = 0;
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      lslc_pkg::REG_RANGE_MIN: rmin = v;
      lslc_pkg::REG_RANGE_MAX: rmax = v;
      lslc_pkg::REG_ANG_START: ang0 = v;
      lslc_pkg::REG_ANG_STEP:  astep = v[11:0];
      lslc_pkg::REG_BEAM_LIM:  blim = v[12:0];
      lslc_pkg::REG_OFFSET_X:  offx = $signed(v);
      lslc_pkg::REG_OFFSET_Y:  offy = $signed(v);
      lslc_pkg::REG_GAP:       gap_mm = v;
      default: ;
    endcase
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    landmark_t lm;
    if (rst_n && out_tvalid && out_tready) begin
      if (landmark_q.size() == 0) begin
        $error("landmark word with no expectation waiting");
        failures++;
      end else begin
        lm = landmark_q.pop_front();
        check_field("centroid_x_mm", lm.cx, out_tdata[17:0]);
        check_field("centroid_y_mm", lm.cy, out_tdata[35:18]);
        check_field("landmark_range_mm", lm.rng, out_tdata[52:36]);
        check_field("landmark_bearing", lm.brg, out_tdata[68:53]);
        check_field("point_count", lm.cnt, out_tdata[81:69]);
        check_field("last_of_scan", lm.last, out_tlast);
      end
    end
  end

  // receiver: random stalls per word, plus one long hold-off on request
  always @(posedge clk) begin
    logic rdy;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (out_tvalid && out_tready && !no_idle) stall_cnt = $urandom_range(0, 7);
    end
    out_tready <= rdy;
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_beam(int unsigned r, bit eos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(r);
    in_tlast  <= eos;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predict_beam(r, eos);
  endtask

  // wait for every expected landmark, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (landmark_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(int unsigned mn, int unsigned mx, int unsigned a0,
                            int unsigned st, int unsigned lim, int ox, int oy,
                            int unsigned gp);
    logic [15:0] vals [8];
    vals = '{16'(mn), 16'(mx), 16'(a0), 16'(st), 16'(lim), 16'(ox), 16'(oy), 16'(gp)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      apply_reg(3'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    set_config($urandom_range(0, 400), $urandom_range(3000, 65535), $urandom_range(0, 65535),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : 4096,
               $signed(16'($urandom)), $signed(16'($urandom)),
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600));
  endtask

  // one scan of a smooth surface with jumps and some wild ranges
  task automatic random_scan(int len);
    int unsigned r;
    r = $urandom_range(200, 20000);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       send_beam($urandom_range(0, 65535), i == len - 1);
        1:       begin r = $urandom_range(150, 25000); send_beam(r, i == len - 1); end
        default: begin
          r = r + $urandom_range(0, 80) - 40;
          send_beam(r & 16'hFFFF, i == len - 1);
        end
      endcase
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_defaults();
    int unsigned rs [10] = '{0, 100, 101, 1000, 1000, 1001, 29999, 30000, 65535, 5000};
    foreach (rs[i]) send_beam(rs[i], i == 9);
    send_beam(0, 1'b1);             // scan end with nothing open
    send_beam(16'hAAAA, 1'b0);
    send_beam(16'h5555, 1'b1);
    drain();
  endtask

  task automatic test_origin_centroid();
    set_config(100, 30000, 0, 64, 4096, -1000, 0, 100);
    send_beam(1000, 1'b1);
    drain();
    set_config(100, 30000, 16384, 0, 4096, 0, -2000, 100);
    send_beam(2000, 1'b0);
    send_beam(2000, 1'b1);
    drain();
  endtask

  task automatic test_empty_window();
    set_config(500, 501, 0, 64, 4096, 0, 0, 100);
    send_beam(500, 1'b0);
    send_beam(501, 1'b0);
    send_beam(502, 1'b1);
    drain();
    set_config(65535, 0, 0, 64, 4096, 0, 0, 100);
    send_beam(1000, 1'b1);
    drain();
  endtask

  task automatic test_beam_limits();
    set_config(100, 30000, 0, 1, 5, 0, 0, 100);
    for (int i = 0; i < 8; i++) send_beam(1000, i == 7);
    drain();
    // limit above the array size
    set_config(100, 30000, 0, 1, 8191, 0, 0, 100);
    for (int i = 0; i < 20; i++) send_beam((i >= 13) ? 1000 : 0, i == 19);
    drain();
  endtask

  task automatic test_extremes();
    set_config(0, 65535, 16'h8000, 4095, 8191, -32768, -32768, 65535);
    random_scan(30);
    drain();
    set_config(0, 65535, 16'h7FFF, 0, 0, 32767, 32767, 0);
    random_scan(10);
    drain();
    set_config(0, 65535, 0, 4095, 4096, 32767, -32768, 0);
    random_scan(40);
    drain();
  endtask

  task automatic test_backpressure();
    set_config(100, 30000, 0, 4095, 4096, 0, 0, 0);
    hold_req = 1'b1;
    random_scan(60);
    drain();
  endtask

  task automatic test_random();
    int sent;
    for (int ph = 0; ph < 11; ph++) begin
      random_config();
      no_idle = (ph % 4 == 3);
      sent = 0;
      while (sent < 150) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        random_scan(len);
        sent += len;
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    apply_reg(lslc_pkg::REG_RANGE_MIN, 16'd100);
    apply_reg(lslc_pkg::REG_RANGE_MAX, 16'd30000);
    apply_reg(lslc_pkg::REG_ANG_START, 16'd0);
    apply_reg(lslc_pkg::REG_ANG_STEP, 16'd64);
    apply_reg(lslc_pkg::REG_BEAM_LIM, 16'd4096);
    apply_reg(lslc_pkg::REG_OFFSET_X, 16'd0);
    apply_reg(lslc_pkg::REG_OFFSET_Y, 16'd0);
    apply_reg(lslc_pkg::REG_GAP, 16'd100);
    beam_idx = 0;
    clear_cluster();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_origin_centroid();
    test_empty_window();
    test_beam_limits();
    test_extremes();
    test_backpressure();
    test_random();
    drain();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
